FILE: rtl/core/svd_pkg.sv
// svd_pkg: constants and types shared by the signed varint decoder
// no dependencies
`default_nettype none

package svd_pkg;

  localparam int unsigned MaxCodeBytes = 5;
  localparam int unsigned GroupBits    = 7;
  localparam int unsigned TopBits      = 6;
  localparam int unsigned AccBits      = 28;
  localparam int unsigned MagBits      = 34;
  localparam int unsigned SeenBits     = 3;
  localparam int unsigned ShiftBits    = 5;

  localparam int unsigned EndBitPos  = 7;
  localparam int unsigned SignBitPos = 6;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTooLong = 2'd1,
    StatusRange   = 2'd2
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] code_byte;
  } byte_stage_t;

  // bit offset of the group that arrives after 'seen' groups
  function automatic logic [ShiftBits-1:0] group_offset(input logic [SeenBits-1:0] seen);
    logic [ShiftBits-1:0] off;
    unique case (seen)
      3'd0:    off = ShiftBits'(0);
      3'd1:    off = ShiftBits'(GroupBits);
      3'd2:    off = ShiftBits'(2 * GroupBits);
      3'd3:    off = ShiftBits'(3 * GroupBits);
      default: off = ShiftBits'(4 * GroupBits);
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/svd_if.sv
// svd_byte_if and svd_result_if: valid/ready channels of the decoder
// no dependencies
`default_nettype none

interface svd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface svd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic [2:0]         code_length;

  modport source (output valid, output value, output status, output code_length, input ready);
  modport sink (input valid, input value, input status, input code_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/svd_in_stage.sv
// svd_in_stage: input register for code bytes
// depends on svd_pkg and svd_byte_if
`default_nettype none

module svd_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  svd_byte_if.sink                code_i,
  input  wire logic               take_i,
  output svd_pkg::byte_stage_t    stage_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       ready;

  assign ready        = !valid_q || take_i;
  assign code_i.ready = ready;

  always_comb begin
    valid_d = valid_q;
    if (ready) begin
      valid_d = code_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && code_i.valid) begin
      byte_q <= code_i.code_byte;
    end
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.code_byte = byte_q;

endmodule

`default_nettype wire

FILE: rtl/core/svd_decode.sv
// svd_decode: magnitude accumulator, range check and result register
// depends on svd_pkg and svd_result_if
`default_nettype none

module svd_decode (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire svd_pkg::byte_stage_t stage_i,
  output logic                      take_o,
  svd_result_if.source              result_o
);

  logic [svd_pkg::AccBits-1:0]   acc_q, acc_d;
  logic [svd_pkg::SeenBits-1:0]  seen_q, seen_d;
  logic                          out_valid_q, out_valid_d;
  logic [31:0]                   value_q, value_d;
  svd_pkg::status_e              status_q, status_d;
  logic [2:0]                    len_q, len_d;

  logic [svd_pkg::ShiftBits-1:0] offset;
  logic [svd_pkg::SeenBits-1:0]  seen_clamped;
  logic                          is_end, is_neg, at_limit, emits, out_free, fire;
  logic [svd_pkg::MagBits-1:0]   mag;
  logic [svd_pkg::AccBits-1:0]   grp_ext;
  logic                          over_pos, over_neg;

  assign seen_clamped = (seen_q > svd_pkg::SeenBits'(svd_pkg::MaxCodeBytes - 1))
                      ? svd_pkg::SeenBits'(svd_pkg::MaxCodeBytes - 1) : seen_q;
  assign offset   = svd_pkg::group_offset(seen_clamped);
  assign is_end   = stage_i.code_byte[svd_pkg::EndBitPos];
  assign is_neg   = stage_i.code_byte[svd_pkg::SignBitPos];
  assign at_limit = seen_clamped == svd_pkg::SeenBits'(svd_pkg::MaxCodeBytes - 1);
  assign emits    = is_end || at_limit;
  assign out_free = !out_valid_q || result_o.ready;
  assign take_o   = stage_i.valid && (!emits || out_free);
  assign fire     = take_o;

  assign mag = {{(svd_pkg::MagBits - svd_pkg::AccBits){1'b0}}, acc_q}
             | ({{(svd_pkg::MagBits - svd_pkg::TopBits){1'b0}},
                 stage_i.code_byte[svd_pkg::TopBits-1:0]} << offset);
  assign grp_ext = {{(svd_pkg::AccBits - svd_pkg::GroupBits){1'b0}},
                    stage_i.code_byte[svd_pkg::GroupBits-1:0]};

  assign over_pos = |mag[33:31];
  assign over_neg = (|mag[33:32]) || (mag[31] && (|mag[30:0]));

  always_comb begin
    acc_d       = acc_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    len_d       = len_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      if (emits) begin
        acc_d       = '0;
        seen_d      = '0;
        out_valid_d = 1'b1;
        if (!is_end) begin
          value_d  = '0;
          status_d = svd_pkg::StatusTooLong;
          len_d    = 3'(svd_pkg::MaxCodeBytes);
        end else begin
          len_d = 3'(seen_clamped) + 3'd1;
          if ((is_neg && over_neg) || (!is_neg && over_pos)) begin
            value_d  = '0;
            status_d = svd_pkg::StatusRange;
          end else begin
            value_d  = is_neg ? (32'd0 - mag[31:0]) : mag[31:0];
            status_d = svd_pkg::StatusOk;
          end
        end
      end else begin
        acc_d  = acc_q | (grp_ext << offset);
        seen_d = seen_clamped + svd_pkg::SeenBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    len_q    <= len_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.value       = value_q;
  assign result_o.status      = status_q;
  assign result_o.code_length = len_q;

endmodule

`default_nettype wire

FILE: rtl/core/signed_varint_decoder.sv
// signed_varint_decoder: top level of the sign-magnitude varint decoder
// depends on svd_pkg, svd_if, svd_in_stage and svd_decode
//
// Takes one code byte per transfer and accepts a new byte every cycle while
// results are taken. A byte passes an input register and then the accumulate
// and range logic into the result register; a result is valid the cycle after
// the decoder takes its end byte. An end byte, or a fifth byte without the end
// bit, waits in the input register while an earlier result is held back by
// the receiver. Bytes without bit 7 add seven magnitude bits; the end byte
// gives sign and the top six bits and yields value, status and code length.
// A fifth byte without the end bit yields a too long result. The decoder
// restarts after every result.
`default_nettype none

module signed_varint_decoder (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  svd_byte_if.sink      code_i,
  svd_result_if.source  result_o
);

  svd_pkg::byte_stage_t stage;
  logic                 take;

  svd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .code_i  (code_i),
    .take_i  (take),
    .stage_o (stage)
  );

  svd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/signed_varint_decoder_checker.sv
// signed_varint_decoder_checker: watches the byte and result channels,
// predicts each decoded result and compares it with the transfer seen
// depends on svd_pkg

module signed_varint_decoder_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic               byte_ready_i,
  input  logic [7:0]         code_byte_i,
  input  logic               result_valid_i,
  input  logic               result_ready_i,
  input  logic signed [31:0] value_i,
  input  logic [1:0]         status_i,
  input  logic [2:0]         code_length_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    svd_pkg::status_e   status;
    logic [2:0]         code_length;
  } decoded_t;

  decoded_t                     decoded_q[$];
  decoded_t                     oldest;
  logic [svd_pkg::AccBits-1:0]  group_acc;
  logic [svd_pkg::SeenBits-1:0] groups_seen;
  int                           fail_count;

  task automatic decode_byte(input logic [7:0] b);
    logic [svd_pkg::MagBits-1:0] mag;
    decoded_t                    res;
    int unsigned                 seen;
    seen = (groups_seen > svd_pkg::MaxCodeBytes - 1) ? svd_pkg::MaxCodeBytes - 1
                                                     : groups_seen;
    if (!b[svd_pkg::EndBitPos]) begin
      if (seen == svd_pkg::MaxCodeBytes - 1) begin
        res.value       = '0;
        res.status      = svd_pkg::StatusTooLong;
        res.code_length = 3'(svd_pkg::MaxCodeBytes);
        decoded_q.push_back(res);
        group_acc   = '0;
        groups_seen = '0;
      end else begin
        group_acc   = group_acc
                    | svd_pkg::AccBits'(svd_pkg::MagBits'(b[svd_pkg::GroupBits-1:0])
                                        << (svd_pkg::GroupBits * seen));
        groups_seen = svd_pkg::SeenBits'(seen + 1);
      end
    end else begin
      mag = svd_pkg::MagBits'(group_acc)
          | (svd_pkg::MagBits'(b[svd_pkg::TopBits-1:0]) << (svd_pkg::GroupBits * seen));
      res.code_length = 3'(seen + 1);
      if (b[svd_pkg::SignBitPos] ? (mag > 34'h0_8000_0000) : (mag > 34'h0_7FFF_FFFF)) begin
        res.value  = '0;
        res.status = svd_pkg::StatusRange;
      end else begin
        res.value  = b[svd_pkg::SignBitPos] ? -mag[31:0] : mag[31:0];
        res.status = svd_pkg::StatusOk;
      end
      decoded_q.push_back(res);
      group_acc   = '0;
      groups_seen = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decoded_q.delete();
      group_acc    = '0;
      groups_seen  = '0;
      fail_count   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // a result is taken only after its end byte has passed the input and result registers
      if (result_valid_i && result_ready_i) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got value %0d status %0d length %0d",
                   $time, value_i, status_i, code_length_i);
        end else begin
          oldest = decoded_q.pop_front();
          if (value_i !== oldest.value || status_i !== oldest.status ||
              code_length_i !== oldest.code_length) begin
            fail_count++;
            $display("%0t: result mismatch, expected value %0d status %0d length %0d,",
                     $time, oldest.value, oldest.status, oldest.code_length);
            $display("%0t:   got value %0d status %0d length %0d",
                     $time, value_i, status_i, code_length_i);
          end
        end
      end
      if (byte_valid_i && byte_ready_i) decode_byte(code_byte_i);
      pending_o    <= decoded_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

FILE: tb/sv/signed_varint_decoder_tb.sv
// signed_varint_decoder_tb: drives code bytes and result back-pressure into
// the decoder and gives the verdict; checking is done by the checker module
// depends on svd_pkg, svd_if, signed_varint_decoder, signed_varint_decoder_checker

module signed_varint_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PhaseBytes = 330;
  localparam int EndDrain   = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_pct   = 0;
  int   stall_pct  = 0;
  int   bytes_sent = 0;

  svd_byte_if   code_if ();
  svd_result_if result_if ();

  signed_varint_decoder u_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .code_i   (code_if),
    .result_o (result_if)
  );

  signed_varint_decoder_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .byte_valid_i   (code_if.valid),
    .byte_ready_i   (code_if.ready),
    .code_byte_i    (code_if.code_byte),
    .result_valid_i (result_if.valid),
    .result_ready_i (result_if.ready),
    .value_i        (result_if.value),
    .status_i       (result_if.status),
    .code_length_i  (result_if.code_length),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    result_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      code_if.valid <= 1'b0;
      @(negedge clk);
    end
    code_if.valid     <= 1'b1;
    code_if.code_byte <= b;
    @(posedge clk);
    while (!code_if.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_code(input int unsigned n, input logic neg, input logic [33:0] mag);
    for (int unsigned i = 0; i + 1 < n; i++) send_byte({1'b0, mag[7*i +: 7]});
    send_byte({1'b1, neg, mag[7*(n-1) +: 6]});
  endtask

  task automatic wait_drained();
    code_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned n;
    logic [33:0] mag;
    pick = $urandom_range(99);
    n    = $urandom_range(1, svd_pkg::MaxCodeBytes);
    mag  = 34'({$urandom(), $urandom()});
    if (pick < 60) begin
      if (n == svd_pkg::MaxCodeBytes && $urandom_range(1)) mag[33:28] = 6'($urandom_range(8));
      send_code(n, 1'($urandom_range(1)), mag);
    end else if (pick < 80) begin
      case ($urandom_range(4))
        0:       mag = 34'h0_7FFF_FFFF;
        1:       mag = 34'h0_8000_0000;
        2:       mag = 34'h0_8000_0001;
        3:       mag = '0;
        default: mag = 34'($urandom_range(2)) + 34'h0_7FFF_FFFE;
      endcase
      send_code(svd_pkg::MaxCodeBytes, 1'($urandom_range(1)), mag);
    end else if (pick < 92) begin
      repeat (svd_pkg::MaxCodeBytes) send_byte({1'b0, 7'($urandom())});
    end else begin
      send_byte(8'($urandom()));
    end
  endtask

  task automatic run_phase(input int idle, input int stall);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = bytes_sent + PhaseBytes;
    while (bytes_sent < stop_at) send_random_unit();
    wait_drained();
  endtask

  initial begin
    code_if.valid     = 1'b0;
    code_if.code_byte = '0;
    result_if.ready   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_code(1, 1'b0, '0);
    send_code(1, 1'b1, '0);
    send_code(1, 1'b1, 34'h0_0000_003F);
    send_code(5, 1'b0, 34'h0_7FFF_FFFF);
    send_code(5, 1'b1, 34'h0_8000_0000);
    send_code(5, 1'b1, 34'h3_FFFF_FFFF);
    repeat (5) send_byte(8'h7F);
    wait_drained();

    run_phase(0, 0);
    run_phase(49, 0);
    run_phase(0, 49);
    run_phase(7, 7);

    repeat (EndDrain) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("signed_varint_decoder test passed");
    end else begin
      $display("signed_varint_decoder test failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("signed_varint_decoder test failed");
    $finish;
  end

endmodule
